FILE: hw/rtl/assert_macros.svh
// Assertion macros shared by the RTL of the decimating complex FIR.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, clocked on clk, off during reset.
`define ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, clocked on clk, off during reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/dcf_pkg.sv
// Package: constants, codes and control types of the decimating complex FIR.
`timescale 1ns / 1ps

package dcf_pkg;

    localparam int MAX_TAPS       = 32;
    localparam int MAX_DECIM      = 256;
    localparam int SAMPLE_BITS    = 16;
    localparam int COEF_BITS      = 16;
    localparam int PROD_BITS      = SAMPLE_BITS + COEF_BITS;
    localparam int ACC_BITS       = 40;
    localparam int ACTION_BITS    = 2;
    localparam int TAP_IDX_BITS   = 5;
    localparam int TAP_CNT_BITS   = 6;
    localparam int DECIM_BITS     = 9;
    localparam int PHASE_BITS     = 8;
    localparam int SCAN_CNT_BITS  = $clog2(2 * MAX_TAPS);
    localparam int CFG_INDEX_BITS = 1;
    localparam int CFG_DATA_BITS  = 9;

    localparam logic [ACTION_BITS-1:0] ACT_PUSH  = 2'd0;
    localparam logic [ACTION_BITS-1:0] ACT_LOAD  = 2'd1;
    localparam logic [ACTION_BITS-1:0] ACT_CLEAR = 2'd2;

    localparam logic [CFG_INDEX_BITS-1:0] REG_TAP_COUNT  = 1'd0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_DECIMATION = 1'd1;

    typedef struct packed {
        logic smp_shift;
        logic smp_clear;
        logic coef_shift;
    } cell_ctrl_t;

    typedef struct packed {
        logic valid;
        logic first;
        logic last;
    } mac_ctrl_t;

endpackage

FILE: hw/rtl/dcf_cell.sv
// One tap cell: a complex history sample and a coefficient, each a link of a ring.
`timescale 1ns / 1ps

module dcf_cell (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dcf_pkg::cell_ctrl_t                    ctrl,
    input  logic                                   coef_load,
    input  logic signed [dcf_pkg::COEF_BITS-1:0]   load_value,
    input  logic signed [dcf_pkg::SAMPLE_BITS-1:0] re_in,
    input  logic signed [dcf_pkg::SAMPLE_BITS-1:0] im_in,
    input  logic signed [dcf_pkg::COEF_BITS-1:0]   coef_in,
    output logic signed [dcf_pkg::SAMPLE_BITS-1:0] re_q,
    output logic signed [dcf_pkg::SAMPLE_BITS-1:0] im_q,
    output logic signed [dcf_pkg::COEF_BITS-1:0]   coef_q
);
    import dcf_pkg::*;

    logic signed [SAMPLE_BITS-1:0] re_reg;
    logic signed [SAMPLE_BITS-1:0] re_next;
    logic signed [SAMPLE_BITS-1:0] im_reg;
    logic signed [SAMPLE_BITS-1:0] im_next;
    logic signed [COEF_BITS-1:0]   coef_reg;
    logic signed [COEF_BITS-1:0]   coef_next;

    always_comb
    begin
        re_next = re_reg;
        im_next = im_reg;
        if (ctrl.smp_clear)
        begin
            re_next = '0;
            im_next = '0;
        end
        else if (ctrl.smp_shift)
        begin
            re_next = re_in;
            im_next = im_in;
        end
    end

    always_comb
    begin
        coef_next = coef_reg;
        if (coef_load)
        begin
            coef_next = load_value;
        end
        else if (ctrl.coef_shift)
        begin
            coef_next = coef_in;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            re_reg <= '0;
            im_reg <= '0;
        end
        else
        begin
            re_reg <= re_next;
            im_reg <= im_next;
        end
    end

    always_ff @(posedge clk)
    begin
        coef_reg <= coef_next;
    end

    assign re_q   = re_reg;
    assign im_q   = im_reg;
    assign coef_q = coef_reg;

endmodule

FILE: hw/rtl/dcf_mac.sv
// Multiply-accumulate at the head of the rings: registered products, 40-bit sums.
`timescale 1ns / 1ps

module dcf_mac (
    input  logic                                   clk,
    input  logic                                   rst_n,
    input  dcf_pkg::mac_ctrl_t                     ctrl,
    input  logic signed [dcf_pkg::SAMPLE_BITS-1:0] smp_re,
    input  logic signed [dcf_pkg::SAMPLE_BITS-1:0] smp_im,
    input  logic signed [dcf_pkg::COEF_BITS-1:0]   coef,
    output logic signed [dcf_pkg::ACC_BITS-1:0]    acc_re,
    output logic signed [dcf_pkg::ACC_BITS-1:0]    acc_im,
    output logic                                   done
);
    import dcf_pkg::*;

    mac_ctrl_t                   s1_reg;
    logic signed [PROD_BITS-1:0] prod_re_reg;
    logic signed [PROD_BITS-1:0] prod_re_next;
    logic signed [PROD_BITS-1:0] prod_im_reg;
    logic signed [PROD_BITS-1:0] prod_im_next;
    logic signed [ACC_BITS-1:0]  ext_re;
    logic signed [ACC_BITS-1:0]  ext_im;
    logic signed [ACC_BITS-1:0]  acc_re_reg;
    logic signed [ACC_BITS-1:0]  acc_re_next;
    logic signed [ACC_BITS-1:0]  acc_im_reg;
    logic signed [ACC_BITS-1:0]  acc_im_next;
    logic                        done_reg;
    logic                        done_next;

    assign prod_re_next = smp_re * coef;
    assign prod_im_next = smp_im * coef;

    assign ext_re = {{(ACC_BITS - PROD_BITS){prod_re_reg[PROD_BITS-1]}}, prod_re_reg};
    assign ext_im = {{(ACC_BITS - PROD_BITS){prod_im_reg[PROD_BITS-1]}}, prod_im_reg};

    always_comb
    begin
        acc_re_next = acc_re_reg;
        acc_im_next = acc_im_reg;
        if (s1_reg.valid)
        begin
            if (s1_reg.first)
            begin
                acc_re_next = ext_re;
                acc_im_next = ext_im;
            end
            else
            begin
                acc_re_next = acc_re_reg + ext_re;
                acc_im_next = acc_im_reg + ext_im;
            end
        end
    end

    assign done_next = s1_reg.valid && s1_reg.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_reg   <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            s1_reg   <= ctrl;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_re_reg <= prod_re_next;
        prod_im_reg <= prod_im_next;
        acc_re_reg  <= acc_re_next;
        acc_im_reg  <= acc_im_next;
    end

    assign acc_re = acc_re_reg;
    assign acc_im = acc_im_reg;
    assign done   = done_reg;

endmodule

FILE: hw/rtl/decimating_complex_fir_top.sv
// Top level of the decimating complex FIR: tap cell rings, control sequencer, output register.
// Usage:
//   Input channel (in_valid/in_stall) carries one item: push a sample, load a
//   coefficient, or clear history and phase. Output channel (out_valid/out_stall)
//   carries one filtered I/Q pair per decimation period once tap_count samples
//   are in. tap_count and decimation are written over cfg_wr_en/cfg_index/cfg_data;
//   the user must write them only while the block is idle; the block does not enforce it.
//   A load, a clear, or a push that yields no output is taken without a stall. A push
//   that yields an output holds in_stall while the rings turn (32 cells, one shared
//   complex MAC at the ring head) and the sum passes the product and accumulator
//   registers into the output register; out_valid rises as that register loads.
//   The output register is taken while the next items come in; if it is still
//   full when a new sum is ready, the block holds in_stall until out_stall drops.
//   Reset clears history, fill and phase, sets tap_count 32 and decimation 1;
//   coefficients are not reset and must be loaded before use.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module decimating_complex_fir_top (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      cfg_wr_en,
    input  logic [dcf_pkg::CFG_INDEX_BITS-1:0]        cfg_index,
    input  logic [dcf_pkg::CFG_DATA_BITS-1:0]         cfg_data,
    input  logic                                      in_valid,
    output logic                                      in_stall,
    input  logic [dcf_pkg::ACTION_BITS-1:0]           action,
    input  logic [dcf_pkg::TAP_IDX_BITS-1:0]          tap_index,
    input  logic signed [dcf_pkg::COEF_BITS-1:0]      tap_value,
    input  logic signed [dcf_pkg::SAMPLE_BITS-1:0]    sample_re,
    input  logic signed [dcf_pkg::SAMPLE_BITS-1:0]    sample_im,
    output logic                                      out_valid,
    input  logic                                      out_stall,
    output logic signed [dcf_pkg::ACC_BITS-1:0]       out_re,
    output logic signed [dcf_pkg::ACC_BITS-1:0]       out_im
);
    import dcf_pkg::*;

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_SCAN  = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;

    localparam logic [SCAN_CNT_BITS-1:0] CNT_TAPS = SCAN_CNT_BITS'(MAX_TAPS);
    localparam logic [SCAN_CNT_BITS-1:0] CNT_HEAD_LAST = SCAN_CNT_BITS'(MAX_TAPS - 1);
    localparam logic [SCAN_CNT_BITS-1:0] CNT_TOP = SCAN_CNT_BITS'(2 * MAX_TAPS - 1);

    logic [TAP_CNT_BITS-1:0]  tap_count_reg;
    logic [TAP_CNT_BITS-1:0]  tap_count_next;
    logic [DECIM_BITS-1:0]    decim_reg;
    logic [DECIM_BITS-1:0]    decim_next;
    logic [TAP_CNT_BITS-1:0]  fill_reg;
    logic [TAP_CNT_BITS-1:0]  fill_next;
    logic [PHASE_BITS-1:0]    phase_reg;
    logic [PHASE_BITS-1:0]    phase_next;
    logic [1:0]               state_reg;
    logic [1:0]               state_next;
    logic [SCAN_CNT_BITS-1:0] cnt_reg;
    logic [SCAN_CNT_BITS-1:0] cnt_next;
    logic                     res_pend_reg;
    logic                     res_pend_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    logic signed [ACC_BITS-1:0] out_re_reg;
    logic signed [ACC_BITS-1:0] out_im_reg;

    logic [TAP_CNT_BITS-1:0]  eff_tc;
    logic [DECIM_BITS-1:0]    eff_decim;
    logic [TAP_CNT_BITS-1:0]  fill_inc;
    logic [DECIM_BITS-1:0]    phase_inc;
    logic [SCAN_CNT_BITS-1:0] base;
    logic [SCAN_CNT_BITS-1:0] scan_end;
    logic                     in_acc;
    logic                     push_acc;
    logic                     load_acc;
    logic                     clear_acc;
    logic                     scan;
    logic                     smp_rot;
    logic                     coef_rot;
    logic                     xfer;
    cell_ctrl_t               cell_ctrl;
    mac_ctrl_t                mac_ctrl;
    logic                     mac_done;
    logic signed [ACC_BITS-1:0] acc_re;
    logic signed [ACC_BITS-1:0] acc_im;

    logic signed [SAMPLE_BITS-1:0] re_q   [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] im_q   [MAX_TAPS];
    logic signed [COEF_BITS-1:0]   coef_q [MAX_TAPS];
    logic signed [SAMPLE_BITS-1:0] tail_re;
    logic signed [SAMPLE_BITS-1:0] tail_im;

    // effective register values
    always_comb
    begin
        if (tap_count_reg == '0)
        begin
            eff_tc = TAP_CNT_BITS'(1);
        end
        else if (tap_count_reg > TAP_CNT_BITS'(MAX_TAPS))
        begin
            eff_tc = TAP_CNT_BITS'(MAX_TAPS);
        end
        else
        begin
            eff_tc = tap_count_reg;
        end
    end

    always_comb
    begin
        if (decim_reg == '0)
        begin
            eff_decim = DECIM_BITS'(1);
        end
        else if (decim_reg > DECIM_BITS'(MAX_DECIM))
        begin
            eff_decim = DECIM_BITS'(MAX_DECIM);
        end
        else
        begin
            eff_decim = decim_reg;
        end
    end

    always_comb
    begin
        tap_count_next = tap_count_reg;
        decim_next     = decim_reg;
        if (cfg_wr_en)
        begin
            case (cfg_index)
                REG_TAP_COUNT:  tap_count_next = cfg_data[TAP_CNT_BITS-1:0];
                REG_DECIMATION: decim_next     = cfg_data[DECIM_BITS-1:0];
                default:        tap_count_next = tap_count_reg;
            endcase
        end
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign in_acc    = in_valid && !in_stall;
    assign push_acc  = in_acc && (action == ACT_PUSH);
    assign load_acc  = in_acc && (action == ACT_LOAD);
    assign clear_acc = in_acc && (action == ACT_CLEAR);

    assign fill_inc  = fill_reg + TAP_CNT_BITS'(1);
    assign phase_inc = DECIM_BITS'(phase_reg) + DECIM_BITS'(1);
    assign base      = CNT_TAPS - SCAN_CNT_BITS'(eff_tc);
    assign scan_end  = CNT_TOP - SCAN_CNT_BITS'(eff_tc);

    assign xfer = (state_reg == ST_DRAIN) && res_pend_reg && (!out_valid_reg || !out_stall);

    // sequencer: sample ring turns alone until cnt reaches base, then both rings
    // turn feeding the MAC until cnt reaches MAX_TAPS, then the coefficient ring
    // turns alone until both are back in place
    always_comb
    begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        fill_next  = fill_reg;
        phase_next = phase_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (clear_acc)
                begin
                    fill_next  = '0;
                    phase_next = '0;
                end
                else if (push_acc)
                begin
                    if (fill_reg < eff_tc)
                    begin
                        fill_next = fill_inc;
                        if (fill_inc == eff_tc)
                        begin
                            phase_next = '0;
                            state_next = ST_SCAN;
                            cnt_next   = '0;
                        end
                    end
                    else if (phase_inc >= eff_decim)
                    begin
                        phase_next = '0;
                        state_next = ST_SCAN;
                        cnt_next   = '0;
                    end
                    else
                    begin
                        phase_next = phase_inc[PHASE_BITS-1:0];
                    end
                end
            end
            ST_SCAN:
            begin
                if (cnt_reg == scan_end)
                begin
                    state_next = ST_DRAIN;
                end
                else
                begin
                    cnt_next = cnt_reg + SCAN_CNT_BITS'(1);
                end
            end
            ST_DRAIN:
            begin
                if (xfer)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    assign scan     = (state_reg == ST_SCAN);
    assign smp_rot  = scan && (cnt_reg < CNT_TAPS);
    assign coef_rot = scan && (cnt_reg >= base);

    assign cell_ctrl.smp_shift  = push_acc || smp_rot;
    assign cell_ctrl.smp_clear  = clear_acc;
    assign cell_ctrl.coef_shift = coef_rot;

    assign mac_ctrl.valid = smp_rot && coef_rot;
    assign mac_ctrl.first = smp_rot && coef_rot && (cnt_reg == base);
    assign mac_ctrl.last  = smp_rot && coef_rot && (cnt_reg == CNT_HEAD_LAST);

    assign tail_re = scan ? re_q[0] : sample_re;
    assign tail_im = scan ? im_q[0] : sample_im;

    genvar k;
    generate
        for (k = 0; k < MAX_TAPS; k++)
        begin : g_cell
            if (k == MAX_TAPS - 1)
            begin : g_tail
                dcf_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .coef_load  (load_acc && (tap_index == TAP_IDX_BITS'(k))),
                    .load_value (tap_value),
                    .re_in      (tail_re),
                    .im_in      (tail_im),
                    .coef_in    (coef_q[0]),
                    .re_q       (re_q[k]),
                    .im_q       (im_q[k]),
                    .coef_q     (coef_q[k])
                );
            end
            else
            begin : g_body
                dcf_cell u_cell (
                    .clk        (clk),
                    .rst_n      (rst_n),
                    .ctrl       (cell_ctrl),
                    .coef_load  (load_acc && (tap_index == TAP_IDX_BITS'(k))),
                    .load_value (tap_value),
                    .re_in      (re_q[k+1]),
                    .im_in      (im_q[k+1]),
                    .coef_in    (coef_q[k+1]),
                    .re_q       (re_q[k]),
                    .im_q       (im_q[k]),
                    .coef_q     (coef_q[k])
                );
            end
        end
    endgenerate

    dcf_mac u_mac (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (mac_ctrl),
        .smp_re (re_q[0]),
        .smp_im (im_q[0]),
        .coef   (coef_q[0]),
        .acc_re (acc_re),
        .acc_im (acc_im),
        .done   (mac_done)
    );

    always_comb
    begin
        res_pend_next = res_pend_reg;
        if (mac_done)
        begin
            res_pend_next = 1'b1;
        end
        else if (xfer)
        begin
            res_pend_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (xfer)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            tap_count_reg <= TAP_CNT_BITS'(MAX_TAPS);
            decim_reg     <= DECIM_BITS'(1);
            fill_reg      <= '0;
            phase_reg     <= '0;
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            res_pend_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            tap_count_reg <= tap_count_next;
            decim_reg     <= decim_next;
            fill_reg      <= fill_next;
            phase_reg     <= phase_next;
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            res_pend_reg  <= res_pend_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (xfer)
        begin
            out_re_reg <= acc_re;
            out_im_reg <= acc_im;
        end
    end

    assign out_valid = out_valid_reg;
    assign out_re    = out_re_reg;
    assign out_im    = out_im_reg;

    `ASSERT_NOW(a_scan_cnt_bound, state_reg == ST_SCAN, cnt_reg <= scan_end, "scan count overrun")
    `ASSERT_NOW(a_done_when_busy, mac_done, state_reg != ST_IDLE, "MAC done while idle")
    `ASSERT_NOW(a_done_not_pending, mac_done, !res_pend_reg, "new sum over a pending one")
    `ASSERT_NEXT(a_xfer_to_idle, xfer, !in_stall && out_valid_reg, "no release after handoff")

endmodule

FILE: bench/tb_top.sv
// Self-checking testbench for the decimating complex FIR: directed table, random phases, predictor.
`timescale 1ns / 1ps

module tb_top;
    import dcf_pkg::*;

    localparam logic [ACTION_BITS-1:0] ACT_UNUSED = 2'd3;
    localparam int SETTLE_CYCLES   = 16;
    localparam int TAIL_CYCLES     = 80;
    localparam int RANDOM_PHASES   = 10;
    localparam int ITEMS_PER_PHASE = 65;

    typedef struct packed {
        logic [ACTION_BITS-1:0]         act;
        logic [TAP_IDX_BITS-1:0]        idx;
        logic signed [COEF_BITS-1:0]    coef;
        logic signed [SAMPLE_BITS-1:0]  re;
        logic signed [SAMPLE_BITS-1:0]  im;
    } item_t;

    typedef struct packed {
        logic signed [ACC_BITS-1:0] re;
        logic signed [ACC_BITS-1:0] im;
    } result_t;

    typedef struct {
        bit                         is_cfg;
        logic [CFG_INDEX_BITS-1:0]  reg_idx;
        logic [CFG_DATA_BITS-1:0]   reg_val;
        item_t                      it;
        bit                         pin;
        result_t                    pin_res;
    } dir_row_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    logic cfg_wr_en = 1'b0;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0] cfg_data = '0;
    logic in_valid = 1'b0;
    logic in_stall;
    logic [ACTION_BITS-1:0] action = ACT_PUSH;
    logic [TAP_IDX_BITS-1:0] tap_index = '0;
    logic signed [COEF_BITS-1:0] tap_value = '0;
    logic signed [SAMPLE_BITS-1:0] sample_re = '0;
    logic signed [SAMPLE_BITS-1:0] sample_im = '0;
    logic out_valid;
    logic out_stall = 1'b0;
    logic signed [ACC_BITS-1:0] out_re;
    logic signed [ACC_BITS-1:0] out_im;

    // Typed-in expectation travels with the item it belongs to.
    bit pin_on = 1'b0;
    result_t pin_res = '0;

    // Filter state as predicted.
    logic signed [COEF_BITS-1:0] tap_bank [MAX_TAPS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] win_re [MAX_TAPS] = '{default: '0};
    logic signed [SAMPLE_BITS-1:0] win_im [MAX_TAPS] = '{default: '0};
    int fill_level = 0;
    int phase_level = 0;
    logic [TAP_CNT_BITS-1:0] taps_reg = TAP_CNT_BITS'(MAX_TAPS);
    logic [DECIM_BITS-1:0] decim_reg = DECIM_BITS'(1);
    result_t expected_sums [$];

    // Stimulus side: taps in use and which coefficients hold a value.
    int gen_taps = MAX_TAPS;
    bit [MAX_TAPS-1:0] coef_loaded = '0;

    int failures = 0;
    int n_push = 0;
    int n_load = 0;
    int n_clear = 0;
    int n_unused = 0;
    int n_results = 0;
    int n_writes = 0;
    int rx_cycles = 0;
    int stall_pct = 0;

    decimating_complex_fir_top dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .action    (action),
        .tap_index (tap_index),
        .tap_value (tap_value),
        .sample_re (sample_re),
        .sample_im (sample_im),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .out_re    (out_re),
        .out_im    (out_im)
    );

    always #5 clk = ~clk;

    function automatic int eff_taps(logic [TAP_CNT_BITS-1:0] v);
        if (v == 0)
            return 1;
        if (v > MAX_TAPS)
            return MAX_TAPS;
        return int'(v);
    endfunction

    function automatic logic signed [15:0] pick16();
        case ($urandom_range(0, 9))
            0: return 16'sh8000;
            1: return 16'sh7FFF;
            2: return 16'sh0000;
            3: return 16'shFFFF;
            default: return 16'($urandom);
        endcase
    endfunction

    function automatic dir_row_t cfg_row(logic [CFG_INDEX_BITS-1:0] r, int v);
        dir_row_t row;
        row = '{default: '0};
        row.is_cfg = 1'b1;
        row.reg_idx = r;
        row.reg_val = CFG_DATA_BITS'(v);
        return row;
    endfunction

    function automatic dir_row_t item_row(logic [ACTION_BITS-1:0] a, int i, int c, int re,
                                          int im, bit pin = 1'b0, longint pre = 0,
                                          longint pim = 0);
        dir_row_t row;
        row = '{default: '0};
        row.it.act = a;
        row.it.idx = TAP_IDX_BITS'(i);
        row.it.coef = COEF_BITS'(c);
        row.it.re = SAMPLE_BITS'(re);
        row.it.im = SAMPLE_BITS'(im);
        row.pin = pin;
        row.pin_res.re = ACC_BITS'(pre);
        row.pin_res.im = ACC_BITS'(pim);
        return row;
    endfunction

    // A push is only issued once every coefficient in use has been loaded.
    function automatic item_t random_item();
        item_t it;
        int r;
        it.idx = TAP_IDX_BITS'($urandom);
        it.coef = pick16();
        it.re = pick16();
        it.im = pick16();
        r = $urandom_range(0, 99);
        if (r < 2)
            it.act = ACT_UNUSED;
        else if (r < 4)
            it.act = ACT_CLEAR;
        else if (r < 12)
            it.act = ACT_LOAD;
        else
            it.act = ACT_PUSH;
        if (it.act == ACT_PUSH) begin
            for (int k = gen_taps - 1; k >= 0; k--) begin
                if (!coef_loaded[k]) begin
                    it.act = ACT_LOAD;
                    it.idx = TAP_IDX_BITS'(k);
                end
            end
        end
        return it;
    endfunction

    task automatic filter_step(input item_t it, output bit emitted, output result_t sum);
        int taps;
        int dec;
        int base;
        logic signed [PROD_BITS-1:0] prod;
        emitted = 1'b0;
        sum = '0;
        taps = eff_taps(taps_reg);
        dec = (decim_reg == 0) ? 1 : ((decim_reg > MAX_DECIM) ? MAX_DECIM : int'(decim_reg));
        case (it.act)
            ACT_LOAD:
                tap_bank[it.idx] = it.coef;
            ACT_CLEAR:
            begin
                for (int k = 0; k < MAX_TAPS; k++) begin
                    win_re[k] = '0;
                    win_im[k] = '0;
                end
                fill_level = 0;
                phase_level = 0;
            end
            ACT_PUSH:
            begin
                for (int k = 0; k < MAX_TAPS - 1; k++) begin
                    win_re[k] = win_re[k + 1];
                    win_im[k] = win_im[k + 1];
                end
                win_re[MAX_TAPS - 1] = it.re;
                win_im[MAX_TAPS - 1] = it.im;
                if (fill_level < taps) begin
                    fill_level++;
                    if (fill_level == taps) begin
                        emitted = 1'b1;
                        phase_level = 0;
                    end
                end
                else if (phase_level + 1 >= dec) begin
                    emitted = 1'b1;
                    phase_level = 0;
                end
                else begin
                    phase_level++;
                end
                if (emitted) begin
                    base = MAX_TAPS - taps;
                    for (int k = 0; k < taps; k++) begin
                        prod = tap_bank[k] * win_re[base + k];
                        sum.re += prod;
                        prod = tap_bank[k] * win_im[base + k];
                        sum.im += prod;
                    end
                end
            end
            default:
                ;
        endcase
    endtask

    task automatic send_item(input item_t it, input bit pin, input result_t pres);
        in_valid <= 1'b1;
        action <= it.act;
        tap_index <= it.idx;
        tap_value <= it.coef;
        sample_re <= it.re;
        sample_im <= it.im;
        pin_on <= pin;
        pin_res <= pres;
        if (it.act == ACT_LOAD)
            coef_loaded[it.idx] = 1'b1;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data <= val;
        if (idx == REG_TAP_COUNT)
            gen_taps = eff_taps(val[TAP_CNT_BITS-1:0]);
        @(posedge clk);
        cfg_wr_en <= 1'b0;
        @(posedge clk);
    endtask

    task automatic drain_results();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_sums.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    always @(posedge clk) begin : scoreboard
        item_t cur;
        bit emitted;
        result_t sum;
        result_t exp_sum;
        if (rst_n) begin
            if (cfg_wr_en) begin
                case (cfg_index)
                    REG_TAP_COUNT:  taps_reg = cfg_data[TAP_CNT_BITS-1:0];
                    REG_DECIMATION: decim_reg = cfg_data[DECIM_BITS-1:0];
                    default:        ;
                endcase
                n_writes++;
            end
            if (in_valid && !in_stall) begin
                cur.act = action;
                cur.idx = tap_index;
                cur.coef = tap_value;
                cur.re = sample_re;
                cur.im = sample_im;
                filter_step(cur, emitted, sum);
                if (pin_on)
                    expected_sums.push_back(pin_res);
                else if (emitted)
                    expected_sums.push_back(sum);
                case (cur.act)
                    ACT_PUSH:  n_push++;
                    ACT_LOAD:  n_load++;
                    ACT_CLEAR: n_clear++;
                    default:   n_unused++;
                endcase
            end
            if (out_valid && !out_stall) begin
                if (expected_sums.size() == 0) begin
                    $error("unexpected result: out_re %0d, out_im %0d", out_re, out_im);
                    failures++;
                end
                else begin
                    exp_sum = expected_sums.pop_front();
                    n_results++;
                    if (out_re !== exp_sum.re) begin
                        $error("out_re mismatch: expected %0d, got %0d", exp_sum.re, out_re);
                        failures++;
                    end
                    if (out_im !== exp_sum.im) begin
                        $error("out_im mismatch: expected %0d, got %0d", exp_sum.im, out_im);
                        failures++;
                    end
                end
            end
        end
    end

    always @(posedge clk) begin : receiver
        if (rx_cycles % 256 == 0) begin
            case ($urandom_range(0, 3))
                0: stall_pct = 0;
                1: stall_pct = 20;
                2: stall_pct = 50;
                default: stall_pct = 85;
            endcase
        end
        rx_cycles++;
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    initial begin : watchdog
        #5_000_000;
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        dir_row_t rows [$];
        item_t it;
        bit gaps_on;
        int burst_left;
        int counted;
        int tc;
        int dc;
        logic [CFG_DATA_BITS-1:0] tc_val;

        rows.push_back(cfg_row(REG_TAP_COUNT, 2));
        rows.push_back(item_row(ACT_LOAD, 0, 32767, 0, 0));
        rows.push_back(item_row(ACT_LOAD, 1, -32768, 0, 0));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 1, 0));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 32767, -32768, 1'b1, -64'sd1073676289,
                                64'sd1073741824));
        rows.push_back(item_row(ACT_PUSH, 0, 0, -32768, 32767, 1'b1, 64'sd2147418113,
                                -64'sd2147418112));
        rows.push_back(item_row(ACT_UNUSED, 31, -1, -1, -1));
        rows.push_back(item_row(ACT_CLEAR, 0, 0, 0, 0));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 5, 7));
        rows.push_back(item_row(ACT_PUSH, 0, 0, -1, -1));
        rows.push_back(item_row(ACT_LOAD, 31, -1, 0, 0));
        rows.push_back(item_row(ACT_LOAD, 2, 21845, 0, 0));
        rows.push_back(item_row(ACT_LOAD, 3, -21846, 0, 0));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 100, -100));
        // growing the window mid-stream resumes filling
        rows.push_back(cfg_row(REG_TAP_COUNT, 3));
        rows.push_back(item_row(ACT_PUSH, 0, 0, -32768, -32768));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 7, -7));
        rows.push_back(cfg_row(REG_TAP_COUNT, 0));
        rows.push_back(cfg_row(REG_DECIMATION, 0));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 32767, 32767, 1'b1, 64'sd1073676289,
                                64'sd1073676289));
        rows.push_back(cfg_row(REG_DECIMATION, 511));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 3, 3));
        rows.push_back(item_row(ACT_PUSH, 0, 0, -3, -3));
        rows.push_back(cfg_row(REG_DECIMATION, 2));
        rows.push_back(item_row(ACT_PUSH, 0, 0, 9, 9));
        rows.push_back(item_row(ACT_CLEAR, 0, 0, 0, 0));

        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (rows[r]) begin
            if (rows[r].is_cfg) begin
                drain_results();
                write_reg(rows[r].reg_idx, rows[r].reg_val);
            end
            else begin
                send_item(rows[r].it, rows[r].pin, rows[r].pin_res);
            end
        end

        for (int p = 0; p < RANDOM_PHASES; p++) begin
            drain_results();
            case (p)
                0: begin tc = 1;  dc = 1;   end
                1: begin tc = 32; dc = 1;   end
                2: begin tc = 32; dc = 256; end
                3: begin tc = 1;  dc = 256; end
                4: begin tc = 0;  dc = 0;   end
                5: begin tc = 63; dc = 511; end
                6: begin tc = 5;  dc = 3;   end
                7: begin tc = 17; dc = 4;   end
                8: begin tc = $urandom_range(0, 63); dc = $urandom_range(0, 6);  end
                default: begin tc = $urandom_range(0, 63); dc = $urandom_range(7, 40); end
            endcase
            tc_val = CFG_DATA_BITS'($urandom);
            tc_val[TAP_CNT_BITS-1:0] = TAP_CNT_BITS'(tc);
            write_reg(REG_TAP_COUNT, tc_val);
            write_reg(REG_DECIMATION, CFG_DATA_BITS'(dc));

            gaps_on = (p % 4 != 1);
            burst_left = $urandom_range(1, 16);
            counted = 0;
            while (counted < ITEMS_PER_PHASE) begin
                it = random_item();
                send_item(it, 1'b0, '0);
                if (it.act != ACT_UNUSED)
                    counted++;
                if (gaps_on) begin
                    burst_left--;
                    if (burst_left == 0) begin
                        in_valid <= 1'b0;
                        repeat ($urandom_range(1, 12)) @(posedge clk);
                        burst_left = $urandom_range(1, 16);
                    end
                end
            end
        end

        drain_results();
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("Stimulus: %0d pushes, %0d coefficient loads, %0d clears, %0d unused actions.",
                 n_push, n_load, n_clear, n_unused);
        $display("Checked %0d filter outputs across %0d register writes.", n_results, n_writes);
        if (failures == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
